// File: hw/rtl/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen fade compositor package
// Shared types and constants for the fade table cells, divider and top level.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int MAX_FADES_DEF = 16;
	localparam logic [15:0] EXTEND_RST = 16'd51;

	localparam int DIV_W  = 24;
	localparam int DIV_VW = 16;
	localparam int DIV_CW = 5;

	localparam int FL_IN    = 0;
	localparam int FL_OUT   = 1;
	localparam int FL_MOD   = 2;
	localparam int FL_STAY  = 3;
	localparam int FL_PURGE = 4;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_EVAL  = 2'd1,
		ACT_CLR_S = 2'd2,
		ACT_CLR_A = 2'd3
	} action_t;

	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [4:0]  mode;
		logic [15:0] span;
		logic [32:0] t_end;
		logic [32:0] t_rst;
	} fade_t;

endpackage
`default_nettype wire

// File: hw/rtl/screen_fade_compositor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen fade compositor
// Fade table kept in a chain of cells, combined into one screen color.
// ----------------------------------------------------------------------------
// The input channel takes one word per command (add, evaluate, clear stay-out,
// clear all); each word yields exactly one result word on the output channel.
// in_stall is high while a word is being worked on. A clear stay-out or
// evaluate walks the table through the cell chain, one fade per cycle except
// while an evaluate waits on a division; an evaluate divides once for each
// ramping fade whose alpha needs a division and, if any fade is kept, once for
// each of the three color means, all on one serial divider.
// The result sits in an output register; a stalled result holds there and the
// next word is still accepted, but its result waits until the register frees.
// stayout_extend is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the table and sets stayout_extend to 51.
// ----------------------------------------------------------------------------
module screen_fade_compositor_top #(
	parameter int MAX_FADES = sfc_pkg::MAX_FADES_DEF,
	parameter int CW = $clog2(MAX_FADES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    action,
	input  wire logic [31:0]   now,
	input  wire logic [15:0]   fade_length,
	input  wire logic [15:0]   hold_length,
	input  wire logic [7:0]    red_in,
	input  wire logic [7:0]    green_in,
	input  wire logic [7:0]    blue_in,
	input  wire logic [7:0]    alpha_in,
	input  wire logic [4:0]    mode_flags,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_alpha,
	output logic               out_modulate,
	output logic [CW-1:0]      active_count,
	output logic               status,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_wdata
);

	localparam int IW = (MAX_FADES > 1) ? $clog2(MAX_FADES) : 1;
	localparam int SW = 8 + CW;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ADD    = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DIVA   = 7'b0001000,
		S_MSTART = 7'b0010000,
		S_MWAIT  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [15:0]     ext_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   kept_q;
	logic [1:0]      ch_q;

	sfc_pkg::action_t act_q;
	logic [31:0]     now_q;
	logic [15:0]     len_q;
	logic [15:0]     hold_q;
	logic [31:0]     col_q;
	logic [4:0]      mode_q;

	logic [SW-1:0]   sum_q [3];
	logic [7:0]      mean_q [3];
	logic [7:0]      amax_q;
	logic            mod_q;
	logic            stat_q;
	logic [7:0]      ra_alpha_q;
	logic            ra_out_q;

	logic            ov_q;
	logic [7:0]      o_red_q, o_green_q, o_blue_q, o_alpha_q;
	logic            o_mod_q, o_stat_q;
	logic [CW-1:0]   o_cnt_q;

	sfc_pkg::fade_t  cells [MAX_FADES];
	sfc_pkg::fade_t  head, upd, bus;
	logic            bus_we, do_shift;
	logic [IW-1:0]   bus_idx;

	logic            accept, scan_step, keep, retire, ahead, need_div;
	logic [32:0]     now33, delta;
	logic [7:0]      direct;
	logic [CW-1:0]   cnt0, wr_pos;
	logic            add_full;
	logic            div_start, div_busy, div_done;
	logic [sfc_pkg::DIV_W-1:0]  div_dvd, div_quo;
	logic [sfc_pkg::DIV_VW-1:0] div_dvs;
	logic [7:0]      ramp;
	logic            out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign now33     = {1'b0, now_q};
	assign scan_step = (state_q == S_SCAN) && (rem_q != '0);
	assign out_free  = !ov_q || !out_stall;

	assign head = cells[0];

	always_comb begin
		upd = head;
		if (act_q == sfc_pkg::ACT_EVAL && head.mode[sfc_pkg::FL_STAY]) begin
			upd.t_rst = now33 + 33'(ext_q);
		end
	end

	assign retire = (now33 > upd.t_rst) && (now33 > upd.t_end);
	assign keep   = (act_q == sfc_pkg::ACT_EVAL) ? !retire : !head.mode[sfc_pkg::FL_STAY];
	assign ahead  = upd.t_end > now33;
	assign delta  = upd.t_end - now33;

	always_comb begin
		need_div = 1'b0;
		direct   = 8'd0;
		if (upd.mode[sfc_pkg::FL_OUT:sfc_pkg::FL_IN] == 2'b00) begin
			direct = upd.alpha;
		end else if (!ahead || upd.span == 16'd0) begin
			direct = upd.mode[sfc_pkg::FL_OUT] ? upd.alpha : 8'd0;
		end else if (delta >= 33'(upd.span)) begin
			direct = upd.mode[sfc_pkg::FL_OUT] ? 8'd0 : upd.alpha;
		end else begin
			need_div = 1'b1;
		end
	end

	assign cnt0     = mode_q[sfc_pkg::FL_PURGE] ? '0 : cnt_q;
	assign add_full = cnt0 >= CW'(MAX_FADES);
	assign wr_pos   = rem_q - 1'b1 + kept_q;

	always_comb begin
		bus      = upd;
		bus_we   = 1'b0;
		bus_idx  = wr_pos[IW-1:0];
		do_shift = scan_step;
		if (state_q == S_ADD) begin
			bus.red   = col_q[7:0];
			bus.green = col_q[15:8];
			bus.blue  = col_q[23:16];
			bus.alpha = col_q[31:24];
			bus.mode  = mode_q;
			bus.span  = len_q;
			if (len_q == 16'd0) begin
				bus.t_end = '0;
				bus.t_rst = 33'(hold_q);
			end else if (mode_q[sfc_pkg::FL_OUT]) begin
				bus.t_end = now33 + 33'(len_q);
				bus.t_rst = now33 + 33'(len_q) + 33'(hold_q);
			end else begin
				bus.t_rst = now33 + 33'(hold_q);
				bus.t_end = now33 + 33'(hold_q) + 33'(len_q);
			end
			bus_we  = !add_full;
			bus_idx = cnt0[IW-1:0];
		end else if (scan_step) begin
			bus_we = keep;
		end
	end

	for (genvar i = 0; i < MAX_FADES; i++) begin : g_cell
		sfc_cell u_cell (
			.clk   (clk),
			.shift (do_shift),
			.load  (bus_we && bus_idx == IW'(i)),
			.nbr   ((i == MAX_FADES - 1) ? bus : cells[(i + 1) % MAX_FADES]),
			.bus   (bus),
			.entry (cells[i])
		);
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = 24'(upd.alpha) * 24'(delta[15:0]);
		div_dvs   = upd.span;
		if (state_q == S_MSTART) begin
			div_start = 1'b1;
			div_dvd   = sfc_pkg::DIV_W'(sum_q[ch_q]);
			div_dvs   = sfc_pkg::DIV_VW'(cnt_q);
		end else if (scan_step && act_q == sfc_pkg::ACT_EVAL && keep && need_div) begin
			div_start = 1'b1;
		end
	end

	sfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ramp = ra_out_q ? ra_alpha_q - div_quo[7:0] : div_quo[7:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (sfc_pkg::action_t'(action) == sfc_pkg::ACT_ADD) begin
						state_d = S_ADD;
					end else if (sfc_pkg::action_t'(action) == sfc_pkg::ACT_CLR_A) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_ADD: state_d = S_DONE;
			S_SCAN: begin
				if (rem_q == '0) begin
					state_d = (act_q == sfc_pkg::ACT_EVAL && kept_q != '0) ? S_MSTART : S_DONE;
				end else if (div_start) begin
					state_d = S_DIVA;
				end
			end
			S_DIVA: begin
				if (div_done) begin
					state_d = S_SCAN;
				end
			end
			S_MSTART: state_d = S_MWAIT;
			S_MWAIT: begin
				if (div_done) begin
					state_d = (ch_q == 2'd2) ? S_DONE : S_MSTART;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ext_q   <= sfc_pkg::EXTEND_RST;
			cnt_q   <= '0;
			rem_q   <= '0;
			kept_q  <= '0;
			ch_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ext_q <= cfg_wdata;
			end
			if (accept) begin
				rem_q  <= cnt_q;
				kept_q <= '0;
				ch_q   <= '0;
				if (sfc_pkg::action_t'(action) == sfc_pkg::ACT_CLR_A) begin
					cnt_q <= '0;
				end
			end
			if (state_q == S_ADD) begin
				cnt_q <= add_full ? cnt0 : cnt0 + 1'b1;
			end
			if (scan_step) begin
				rem_q  <= rem_q - 1'b1;
				kept_q <= kept_q + CW'(keep);
			end
			if (state_q == S_SCAN && rem_q == '0) begin
				cnt_q <= kept_q;
			end
			if (state_q == S_MWAIT && div_done) begin
				ch_q <= ch_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= sfc_pkg::action_t'(action);
			now_q    <= now;
			len_q    <= fade_length;
			hold_q   <= hold_length;
			col_q    <= {alpha_in, blue_in, green_in, red_in};
			mode_q   <= mode_flags;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			mean_q[0] <= '0;
			mean_q[1] <= '0;
			mean_q[2] <= '0;
			amax_q   <= '0;
			mod_q    <= 1'b0;
			stat_q   <= 1'b0;
		end
		if (state_q == S_ADD) begin
			stat_q <= add_full;
		end
		if (scan_step && act_q == sfc_pkg::ACT_EVAL && keep) begin
			sum_q[0] <= sum_q[0] + SW'(upd.red);
			sum_q[1] <= sum_q[1] + SW'(upd.green);
			sum_q[2] <= sum_q[2] + SW'(upd.blue);
			if (upd.mode[sfc_pkg::FL_MOD]) begin
				mod_q <= 1'b1;
			end
			if (!need_div && direct > amax_q) begin
				amax_q <= direct;
			end
			ra_alpha_q <= upd.alpha;
			ra_out_q   <= upd.mode[sfc_pkg::FL_OUT];
		end
		if (state_q == S_DIVA && div_done && ramp > amax_q) begin
			amax_q <= ramp;
		end
		if (state_q == S_MWAIT && div_done) begin
			mean_q[ch_q] <= div_quo[7:0];
		end
		if (state_q == S_DONE && out_free) begin
			o_red_q   <= mean_q[0];
			o_green_q <= mean_q[1];
			o_blue_q  <= mean_q[2];
			o_alpha_q <= amax_q;
			o_mod_q   <= mod_q;
			o_stat_q  <= stat_q;
			o_cnt_q   <= cnt_q;
		end
	end

	assign out_valid    = ov_q;
	assign out_red      = o_red_q;
	assign out_green    = o_green_q;
	assign out_blue     = o_blue_q;
	assign out_alpha    = o_alpha_q;
	assign out_modulate = o_mod_q;
	assign active_count = o_cnt_q;
	assign status       = o_stat_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_FADES))
		else $error("fade count exceeds table size");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rem_q + kept_q <= CW'(MAX_FADES)))
		else $error("scan pointers exceed table size");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (active_count == CW'(MAX_FADES)))
		else $error("add dropped while table not full");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule
`default_nettype wire

// File: hw/rtl/sfc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fade table cell
// Holds one fade; shifts in its upper neighbor or loads from the write bus.
// ----------------------------------------------------------------------------
module sfc_cell (
	input  wire logic          clk,
	input  wire logic          shift,
	input  wire logic          load,
	input  wire sfc_pkg::fade_t nbr,
	input  wire sfc_pkg::fade_t bus,
	output sfc_pkg::fade_t     entry
);

	sfc_pkg::fade_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= bus;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// File: hw/rtl/sfc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfc_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sfc_pkg::DIV_W-1:0]    dividend,
	input  wire logic [sfc_pkg::DIV_VW-1:0]   divisor,
	output logic                              busy,
	output logic                              done,
	output logic [sfc_pkg::DIV_W-1:0]         quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [sfc_pkg::DIV_CW-1:0]    cnt_q;
	logic [sfc_pkg::DIV_W-1:0]     quo_q;
	logic [sfc_pkg::DIV_VW-1:0]    rem_q;
	logic [sfc_pkg::DIV_VW-1:0]    dvs_q;
	logic [sfc_pkg::DIV_VW:0]      trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[sfc_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= sfc_pkg::DIV_CW'(sfc_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == sfc_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? sfc_pkg::DIV_VW'(trial - {1'b0, dvs_q})
			              : sfc_pkg::DIV_VW'(trial);
			quo_q <= {quo_q[sfc_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: tb/sv/tb_screen_fade_compositor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen fade compositor testbench
// Drives add, evaluate and clear words with random gaps and output stalls,
// predicts each result word from a local copy of the fade table and the
// stay-out extension register, and compares every field in order.
// ----------------------------------------------------------------------------
module tb_screen_fade_compositor_top;
	import sfc_pkg::*;

	localparam int NFADE = MAX_FADES_DEF;
	localparam int RUN_LIMIT = 3000000;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       modulate;
		logic [4:0] count;
		logic       status;
	} screen_word_t;

	class fade_scoreboard;
		logic [7:0]  f_red[NFADE];
		logic [7:0]  f_green[NFADE];
		logic [7:0]  f_blue[NFADE];
		logic [7:0]  f_alpha[NFADE];
		logic [4:0]  f_mode[NFADE];
		logic [15:0] f_span[NFADE];
		logic [32:0] f_end[NFADE];
		logic [32:0] f_rst[NFADE];
		int unsigned held;
		logic [15:0] extend;
		screen_word_t pending[$];
		int errors;

		function new();
			held = 0;
			extend = EXTEND_RST;
			errors = 0;
		endfunction

		function void copy_fade(int dst, int src);
			f_red[dst] = f_red[src];
			f_green[dst] = f_green[src];
			f_blue[dst] = f_blue[src];
			f_alpha[dst] = f_alpha[src];
			f_mode[dst] = f_mode[src];
			f_span[dst] = f_span[src];
			f_end[dst] = f_end[src];
			f_rst[dst] = f_rst[src];
		endfunction

		function logic [7:0] ramped_alpha(int k, logic [32:0] t);
			logic ahead;
			longint unsigned delta;
			longint unsigned q;
			ahead = f_end[k] > t;
			delta = ahead ? f_end[k] - t : t - f_end[k];
			q = (f_span[k] != 0) ? (longint'(f_alpha[k]) * delta) / f_span[k] : 0;
			if (!f_mode[k][FL_IN] && !f_mode[k][FL_OUT])
				return f_alpha[k];
			if (f_mode[k][FL_OUT]) begin
				if (!ahead)
					return f_alpha[k];
				return (q >= f_alpha[k]) ? 8'd0 : f_alpha[k] - q[7:0];
			end
			if (!ahead)
				return 8'd0;
			return (q >= f_alpha[k]) ? f_alpha[k] : q[7:0];
		endfunction

		function void note_word(action_t act, logic [31:0] t, logic [15:0] len,
				logic [15:0] hold, logic [7:0] r, logic [7:0] g, logic [7:0] b,
				logic [7:0] a, logic [4:0] mode);
			screen_word_t res;
			logic [32:0] t33;
			int w;
			int unsigned sr, sg, sb;
			logic [7:0] al;
			t33 = {1'b0, t};
			res = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 5'd0, 1'b0};
			case (act)
				ACT_ADD: begin
					if (mode[FL_PURGE])
						held = 0;
					if (held >= NFADE) begin
						res.status = 1'b1;
					end else begin
						f_red[held] = r;
						f_green[held] = g;
						f_blue[held] = b;
						f_alpha[held] = a;
						f_mode[held] = mode;
						f_span[held] = len;
						if (len == 0) begin
							f_end[held] = 33'd0;
							f_rst[held] = {17'd0, hold};
						end else if (mode[FL_OUT]) begin
							f_end[held] = t33 + len;
							f_rst[held] = f_end[held] + hold;
						end else begin
							f_rst[held] = t33 + hold;
							f_end[held] = f_rst[held] + len;
						end
						held++;
					end
				end
				ACT_EVAL: begin
					w = 0;
					sr = 0;
					sg = 0;
					sb = 0;
					for (int k = 0; k < held; k++) begin
						if (f_mode[k][FL_STAY])
							f_rst[k] = t33 + extend;
						if (t33 > f_rst[k] && t33 > f_end[k])
							continue;
						copy_fade(w, k);
						w++;
					end
					held = w;
					for (int k = 0; k < held; k++) begin
						sr += f_red[k];
						sg += f_green[k];
						sb += f_blue[k];
						al = ramped_alpha(k, t33);
						if (al > res.alpha)
							res.alpha = al;
						if (f_mode[k][FL_MOD])
							res.modulate = 1'b1;
					end
					if (held != 0) begin
						res.red = 8'(sr / held);
						res.green = 8'(sg / held);
						res.blue = 8'(sb / held);
					end
				end
				ACT_CLR_S: begin
					w = 0;
					for (int k = 0; k < held; k++) begin
						if (!f_mode[k][FL_STAY]) begin
							copy_fade(w, k);
							w++;
						end
					end
					held = w;
				end
				default: held = 0;
			endcase
			res.count = 5'(held);
			pending.push_back(res);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_result(screen_word_t got);
			screen_word_t want;
			if (pending.size() == 0) begin
				report("unexpected word, count", got.count, -1);
			end else begin
				want = pending.pop_front();
				if (got.red !== want.red) report("out_red", got.red, want.red);
				if (got.green !== want.green) report("out_green", got.green, want.green);
				if (got.blue !== want.blue) report("out_blue", got.blue, want.blue);
				if (got.alpha !== want.alpha) report("out_alpha", got.alpha, want.alpha);
				if (got.modulate !== want.modulate)
					report("out_modulate", got.modulate, want.modulate);
				if (got.count !== want.count) report("active_count", got.count, want.count);
				if (got.status !== want.status) report("status", got.status, want.status);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [31:0] now = '0;
	logic [15:0] fade_length = '0;
	logic [15:0] hold_length = '0;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic [7:0] alpha_in = '0;
	logic [4:0] mode_flags = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_red, out_green, out_blue, out_alpha;
	logic out_modulate;
	logic [4:0] active_count;
	logic status;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	fade_scoreboard sb = new();
	int cycles = 0;
	bit stall_quiet = 1'b0;
	logic [31:0] tcur;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	screen_fade_compositor_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .now(now), .fade_length(fade_length),
		.hold_length(hold_length), .red_in(red_in), .green_in(green_in),
		.blue_in(blue_in), .alpha_in(alpha_in), .mode_flags(mode_flags),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha), .out_modulate(out_modulate),
		.active_count(active_count), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	function int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("** screen_fade_compositor_top: FAILED **");
			$finish;
		end
		if (in_valid && !in_stall)
			sb.note_word(action_t'(action), now, fade_length, hold_length,
				red_in, green_in, blue_in, alpha_in, mode_flags);
		if (out_valid && !out_stall)
			sb.check_result('{out_red, out_green, out_blue, out_alpha,
				out_modulate, active_count, status});
		if ($urandom_range(299) == 0)
			stall_quiet <= !stall_quiet;
		if (stall_quiet || !arst_n)
			out_stall <= 1'b0;
		else if (out_stall)
			out_stall <= ($urandom_range(99) < 70) ? ($urandom_range(9) != 0) : 1'b0;
		else
			out_stall <= ($urandom_range(99) < 20);
	end

	task send_word(action_t act, logic [31:0] t, logic [15:0] len, logic [15:0] hold,
			logic [31:0] rgba, logic [4:0] mode);
		int gap;
		action <= act;
		now <= t;
		fade_length <= len;
		hold_length <= hold;
		{alpha_in, blue_in, green_in, red_in} <= rgba;
		mode_flags <= mode;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		gap = stall_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_extend(logic [15:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.extend = value;
		@(posedge clk);
	endtask

	task random_word();
		int p;
		logic [15:0] len, hold;
		logic [4:0] mode;
		p = $urandom_range(99);
		mode = 5'($urandom_range(31));
		if ($urandom_range(7) != 0)
			mode[FL_PURGE] = 1'b0;
		len = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
		                               : 16'($urandom_range(600));
		hold = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
		                                : 16'($urandom_range(300));
		if ($urandom_range(15) == 0)
			len = 16'd0;
		if (p < 45) begin
			send_word(ACT_ADD, tcur, len, hold, $urandom, mode);
		end else if (p < 88) begin
			tcur = tcur + $urandom_range(0, 120);
			send_word(ACT_EVAL, tcur, 16'($urandom), 16'($urandom), $urandom,
				5'($urandom_range(31)));
		end else if (p < 93) begin
			send_word(ACT_CLR_S, tcur, 16'($urandom), 16'($urandom), $urandom,
				5'($urandom_range(31)));
		end else if (p < 95) begin
			send_word(ACT_CLR_A, tcur, 16'($urandom), 16'($urandom), $urandom,
				5'($urandom_range(31)));
		end else begin
			send_word($urandom_range(1) ? ACT_EVAL : ACT_ADD, $urandom, len, hold,
				$urandom, mode);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tcur = 32'd1000;
		send_word(ACT_EVAL, tcur, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_ADD, tcur, 16'd100, 16'd50, 32'hFF0000FF, 5'b00010);
		send_word(ACT_ADD, tcur, 16'd100, 16'd50, 32'h80FFFF00, 5'b00001);
		send_word(ACT_ADD, tcur, 16'd0, 16'd20, 32'hFFFFFFFF, 5'b00111);
		send_word(ACT_ADD, tcur, 16'hFFFF, 16'hFFFF, 32'h7F010203, 5'b01100);
		send_word(ACT_EVAL, tcur + 30, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_EVAL, tcur + 120, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_EVAL, tcur + 400, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_CLR_S, tcur, 16'd0, 16'd0, 32'd0, 5'd0);
		for (int i = 0; i < 17; i++)
			send_word(ACT_ADD, tcur, 16'd10, 16'd10, $urandom, 5'b01000);
		send_word(ACT_ADD, tcur, 16'd10, 16'd10, 32'hFFFFFFFF, 5'b11111);
		send_word(ACT_EVAL, 32'hFFFFFFFF, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_ADD, 32'hFFFFFFF0, 16'hFFFF, 16'hFFFF, 32'hFF808080, 5'b00010);
		send_word(ACT_EVAL, 32'hFFFFFFFF, 16'd0, 16'd0, 32'd0, 5'd0);
		send_word(ACT_CLR_A, tcur, 16'd0, 16'd0, 32'd0, 5'd0);

		write_extend(16'd0);
		tcur = $urandom;
		repeat (250) random_word();
		write_extend(16'hFFFF);
		repeat (250) random_word();
		write_extend(16'($urandom_range(1, 400)));
		repeat (250) random_word();
		write_extend(EXTEND_RST);
		repeat (250) random_word();

		drain();
		if (sb.errors == 0)
			$display("** screen_fade_compositor_top: PASSED **");
		else
			$display("** screen_fade_compositor_top: FAILED **");
		$finish;
	end

endmodule
